>>> src/bzs_pkg.sv
`default_nettype none

package bzs_pkg;

    // seven control points go out for every item
    localparam int NUM_POINTS = 7;
    localparam int IDX_W      = 3;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx FIRST_IDX = t_idx'(0);
    localparam t_idx LAST_IDX  = t_idx'(NUM_POINTS - 1);

endpackage

`default_nettype wire

>>> src/bzs_lerp.sv
`default_nettype none

// One coordinate of one interpolation: (a*u + b*t + half) >>> T, two register stages.
module bzs_lerp #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic signed [COORD_WIDTH-1:0] i_a,
    input  wire logic signed [COORD_WIDTH-1:0] i_b,
    input  wire logic        [T_FRAC_BITS:0]   i_t,
    input  wire logic        [T_FRAC_BITS:0]   i_u,
    output logic signed      [COORD_WIDTH-1:0] o_q
);

    localparam int SW = COORD_WIDTH + T_FRAC_BITS + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (T_FRAC_BITS - 1);

    logic signed [SW-1:0] r_pa;
    logic signed [SW-1:0] r_pb;
    logic signed [SW-1:0] w_sum;

    // stage 1: weight both endpoints
    always_ff @(posedge i_clk) begin
        r_pa <= SW'(i_a) * SW'($signed({1'b0, i_u}));
        r_pb <= SW'(i_b) * SW'($signed({1'b0, i_t}));
    end

    // stage 2: add, round, floor shift
    assign w_sum = r_pa + r_pb + HALF;

    always_ff @(posedge i_clk) begin
        o_q <= w_sum[T_FRAC_BITS+COORD_WIDTH-1:T_FRAC_BITS];
    end

endmodule

`default_nettype wire

>>> src/bzs_serializer.sv
`default_nettype none

// Holds the seven points of one item and sends one per cycle.
module bzs_serializer #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire logic [COORD_WIDTH-1:0]  i_pt_x [0:bzs_pkg::NUM_POINTS-1],
    input  wire logic [COORD_WIDTH-1:0]  i_pt_y [0:bzs_pkg::NUM_POINTS-1],
    output logic                         o_valid,
    output bzs_pkg::t_idx                o_point_index,
    output logic [COORD_WIDTH-1:0]       o_out_x,
    output logic [COORD_WIDTH-1:0]       o_out_y,
    output logic                         o_last
);

    import bzs_pkg::*;

    logic [COORD_WIDTH-1:0] r_sh_x [0:NUM_POINTS-1];
    logic [COORD_WIDTH-1:0] r_sh_y [0:NUM_POINTS-1];
    logic                   r_active;
    t_idx                   r_cnt;

    // control: index count and active flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= FIRST_IDX;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_cnt    <= FIRST_IDX;
        end else if (r_active) begin
            r_cnt <= r_cnt + t_idx'(1);
            if (r_cnt == LAST_IDX) begin
                r_active <= 1'b0;
            end
        end
    end

    // point shift line, head is on the output
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sh_x <= i_pt_x;
            r_sh_y <= i_pt_y;
        end else begin
            for (int k = 0; k < NUM_POINTS - 1; k++) begin
                r_sh_x[k] <= r_sh_x[k+1];
                r_sh_y[k] <= r_sh_y[k+1];
            end
        end
    end

    assign o_valid       = r_active;
    assign o_point_index = r_cnt;
    assign o_out_x       = r_sh_x[0];
    assign o_out_y       = r_sh_y[0];
    assign o_last        = (r_cnt == LAST_IDX);

    // a new item never lands on a run still in flight
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_active || r_cnt == LAST_IDX))
        else $error("serializer loaded mid-run");

    // a run steps through the indexes without gaps
    a_run_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_cnt != LAST_IDX) |=>
            (r_active && r_cnt == $past(r_cnt) + t_idx'(1)))
        else $error("serializer run broken");

    // without a load, the run ends after the last point
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_cnt == LAST_IDX && !i_load) |=> !r_active)
        else $error("serializer ran past last point");

endmodule

`default_nettype wire

>>> src/cubic_bezier_split.sv
`default_nettype none

// Channel  | Ports                                       | Handshake
// ---------+---------------------------------------------+---------------------------------
// input    | i_p0_x .. i_p3_y, i_split_t                 | accepted when start && !busy
// result   | o_point_index, o_out_x, o_out_y, o_last     | o_valid strobe, one cycle each
//
// The result port sends seven points per item, one per cycle, and busy stays high after
// each accepted item until the spacing count runs out, so the runs of two items never overlap.
// The math is a 7-stage pipeline (input register, then three lerp levels of multiply + sum).
// Reset (synchronous, active low) clears the valid bits, the busy count and the output run.
// The receiver cannot stall; the pipeline never holds.
module cubic_bezier_split #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_p0_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p0_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  wire logic        [T_FRAC_BITS:0]   i_split_t,
    output logic                               o_valid,
    output bzs_pkg::t_idx                      o_point_index,
    output logic signed      [COORD_WIDTH-1:0] o_out_x,
    output logic signed      [COORD_WIDTH-1:0] o_out_y,
    output logic                               o_last
);

    import bzs_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int STAGES = 7;
    localparam logic [T_FRAC_BITS:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic                   w_accept;
    logic [T_FRAC_BITS:0]   w_t_sat;
    logic                   r_v [0:STAGES-1];
    t_idx                   r_gap;

    logic signed [W-1:0]    r_s0_x [0:3];
    logic signed [W-1:0]    r_s0_y [0:3];
    logic [T_FRAC_BITS:0]   r_s0_t;
    logic [T_FRAC_BITS:0]   r_s0_u;
    logic [T_FRAC_BITS:0]   r_td [1:4];
    logic [T_FRAC_BITS:0]   r_ud [1:4];

    logic signed [W-1:0]    r_p0x_d [1:6];
    logic signed [W-1:0]    r_p0y_d [1:6];
    logic signed [W-1:0]    r_p3x_d [1:6];
    logic signed [W-1:0]    r_p3y_d [1:6];
    logic signed [W-1:0]    r_q1x_d [3:6];
    logic signed [W-1:0]    r_q1y_d [3:6];
    logic signed [W-1:0]    r_q5x_d [3:6];
    logic signed [W-1:0]    r_q5y_d [3:6];
    logic signed [W-1:0]    r_q2x_d [5:6];
    logic signed [W-1:0]    r_q2y_d [5:6];
    logic signed [W-1:0]    r_q4x_d [5:6];
    logic signed [W-1:0]    r_q4y_d [5:6];

    logic signed [W-1:0]    w_l1_x [0:2];
    logic signed [W-1:0]    w_l1_y [0:2];
    logic signed [W-1:0]    w_l2_x [0:1];
    logic signed [W-1:0]    w_l2_y [0:1];
    logic signed [W-1:0]    w_l3_x;
    logic signed [W-1:0]    w_l3_y;

    logic [W-1:0]           w_pt_x [0:NUM_POINTS-1];
    logic [W-1:0]           w_pt_y [0:NUM_POINTS-1];
    logic [W-1:0]           w_out_x;
    logic [W-1:0]           w_out_y;

    assign w_accept = start && !busy;
    assign busy     = (r_gap != FIRST_IDX);
    assign w_t_sat  = (i_split_t > ONE) ? ONE : i_split_t;

    // spacing count: one item per run of seven result points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= FIRST_IDX;
        end else if (w_accept) begin
            r_gap <= LAST_IDX;
        end else if (busy) begin
            r_gap <= r_gap - t_idx'(1);
        end
    end

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= w_accept;
            for (int k = 1; k < STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: input register, t saturated to one
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s0_x[0] <= i_p0_x;
            r_s0_y[0] <= i_p0_y;
            r_s0_x[1] <= i_p1_x;
            r_s0_y[1] <= i_p1_y;
            r_s0_x[2] <= i_p2_x;
            r_s0_y[2] <= i_p2_y;
            r_s0_x[3] <= i_p3_x;
            r_s0_y[3] <= i_p3_y;
            r_s0_t    <= w_t_sat;
            r_s0_u    <= ONE - w_t_sat;
        end
    end

    // delay lines for weights and for points that skip levels
    always_ff @(posedge i_clk) begin
        r_td[1]    <= r_s0_t;
        r_ud[1]    <= r_s0_u;
        r_p0x_d[1] <= r_s0_x[0];
        r_p0y_d[1] <= r_s0_y[0];
        r_p3x_d[1] <= r_s0_x[3];
        r_p3y_d[1] <= r_s0_y[3];
        for (int k = 2; k <= 4; k++) begin
            r_td[k] <= r_td[k-1];
            r_ud[k] <= r_ud[k-1];
        end
        for (int k = 2; k <= 6; k++) begin
            r_p0x_d[k] <= r_p0x_d[k-1];
            r_p0y_d[k] <= r_p0y_d[k-1];
            r_p3x_d[k] <= r_p3x_d[k-1];
            r_p3y_d[k] <= r_p3y_d[k-1];
        end
        r_q1x_d[3] <= w_l1_x[0];
        r_q1y_d[3] <= w_l1_y[0];
        r_q5x_d[3] <= w_l1_x[2];
        r_q5y_d[3] <= w_l1_y[2];
        for (int k = 4; k <= 6; k++) begin
            r_q1x_d[k] <= r_q1x_d[k-1];
            r_q1y_d[k] <= r_q1y_d[k-1];
            r_q5x_d[k] <= r_q5x_d[k-1];
            r_q5y_d[k] <= r_q5y_d[k-1];
        end
        r_q2x_d[5] <= w_l2_x[0];
        r_q2y_d[5] <= w_l2_y[0];
        r_q4x_d[5] <= w_l2_x[1];
        r_q4y_d[5] <= w_l2_y[1];
        r_q2x_d[6] <= r_q2x_d[5];
        r_q2y_d[6] <= r_q2y_d[5];
        r_q4x_d[6] <= r_q4x_d[5];
        r_q4y_d[6] <= r_q4y_d[5];
    end

    // level 1: P01, P12, P23 (stages 1-2)
    for (genvar j = 0; j < 3; j++) begin : g_l1
        bzs_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_lx (
            .i_clk (i_clk),
            .i_a   (r_s0_x[j]),
            .i_b   (r_s0_x[j+1]),
            .i_t   (r_s0_t),
            .i_u   (r_s0_u),
            .o_q   (w_l1_x[j])
        );
        bzs_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_ly (
            .i_clk (i_clk),
            .i_a   (r_s0_y[j]),
            .i_b   (r_s0_y[j+1]),
            .i_t   (r_s0_t),
            .i_u   (r_s0_u),
            .o_q   (w_l1_y[j])
        );
    end

    // level 2: point 2 from (1, P12), point 4 from (P12, 5) (stages 3-4)
    for (genvar j = 0; j < 2; j++) begin : g_l2
        bzs_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_lx (
            .i_clk (i_clk),
            .i_a   (w_l1_x[j]),
            .i_b   (w_l1_x[j+1]),
            .i_t   (r_td[2]),
            .i_u   (r_ud[2]),
            .o_q   (w_l2_x[j])
        );
        bzs_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_ly (
            .i_clk (i_clk),
            .i_a   (w_l1_y[j]),
            .i_b   (w_l1_y[j+1]),
            .i_t   (r_td[2]),
            .i_u   (r_ud[2]),
            .o_q   (w_l2_y[j])
        );
    end

    // level 3: curve point (stages 5-6)
    bzs_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_l3x (
        .i_clk (i_clk),
        .i_a   (w_l2_x[0]),
        .i_b   (w_l2_x[1]),
        .i_t   (r_td[4]),
        .i_u   (r_ud[4]),
        .o_q   (w_l3_x)
    );
    bzs_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_l3y (
        .i_clk (i_clk),
        .i_a   (w_l2_y[0]),
        .i_b   (w_l2_y[1]),
        .i_t   (r_td[4]),
        .i_u   (r_ud[4]),
        .o_q   (w_l3_y)
    );

    // gather the seven points in index order
    assign w_pt_x[0] = r_p0x_d[6];
    assign w_pt_y[0] = r_p0y_d[6];
    assign w_pt_x[1] = r_q1x_d[6];
    assign w_pt_y[1] = r_q1y_d[6];
    assign w_pt_x[2] = r_q2x_d[6];
    assign w_pt_y[2] = r_q2y_d[6];
    assign w_pt_x[3] = w_l3_x;
    assign w_pt_y[3] = w_l3_y;
    assign w_pt_x[4] = r_q4x_d[6];
    assign w_pt_y[4] = r_q4y_d[6];
    assign w_pt_x[5] = r_q5x_d[6];
    assign w_pt_y[5] = r_q5y_d[6];
    assign w_pt_x[6] = r_p3x_d[6];
    assign w_pt_y[6] = r_p3y_d[6];

    bzs_serializer #(.COORD_WIDTH(W)) u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (r_v[STAGES-1]),
        .i_pt_x        (w_pt_x),
        .i_pt_y        (w_pt_y),
        .o_valid       (o_valid),
        .o_point_index (o_point_index),
        .o_out_x       (w_out_x),
        .o_out_y       (w_out_y),
        .o_last        (o_last)
    );

    assign o_out_x = $signed(w_out_x);
    assign o_out_y = $signed(w_out_y);

    // an accepted item holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after accept");

    // an item leaving the pipeline starts a run at point 0
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STAGES-1] |=> (o_valid && o_point_index == FIRST_IDX))
        else $error("run did not start at point 0");

    // no two items in the pipeline closer than a run
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> !r_v[1] && !r_v[2] && !r_v[3] && !r_v[4] && !r_v[5] && !r_v[6])
        else $error("items too close in pipeline");

endmodule

`default_nettype wire

>>> verif/bezier_split_checker.sv
`default_nettype none

// Watches the item and result channels of cubic_bezier_split, predicts the
// seven subdivided control points of every accepted item and compares each
// emitted point against the oldest prediction.
module bezier_split_checker #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_p0_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p0_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  wire logic        [T_FRAC_BITS:0]   i_split_t,
    input  wire logic                          o_valid,
    input  wire bzs_pkg::t_idx                 o_point_index,
    input  wire logic signed [COORD_WIDTH-1:0] o_out_x,
    input  wire logic signed [COORD_WIDTH-1:0] o_out_y,
    input  wire logic                          o_last,
    output int                                 o_fail_count,
    output int                                 o_points_pending
);

    import bzs_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [NUM_POINTS-1:0][COORD_WIDTH-1:0] axis_points_t;

    typedef struct {
        t_idx   index;
        coord_t x;
        coord_t y;
        logic   last;
    } ctrl_point_t;

    localparam longint ONE_T = longint'(1) << T_FRAC_BITS;

    // subdivided points still owed by the block, oldest first
    ctrl_point_t expected_points[$];

    // rounded fixed-point interpolation; >>> on a signed sum floors
    function automatic coord_t lerp_q16(coord_t a, coord_t b, longint t);
        longint acc;
        acc = longint'(a) * (ONE_T - t) + longint'(b) * t + ONE_T / 2;
        return coord_t'(acc >>> T_FRAC_BITS);
    endfunction

    // de Casteljau on one axis: left half 0..3, right half 3..6
    function automatic axis_points_t split_axis(coord_t a0, coord_t a1, coord_t a2,
                                                coord_t a3, longint t);
        axis_points_t q;
        coord_t       mid;
        mid  = lerp_q16(a1, a2, t);
        q[0] = a0;
        q[6] = a3;
        q[1] = lerp_q16(a0, a1, t);
        q[5] = lerp_q16(a2, a3, t);
        q[2] = lerp_q16(coord_t'(q[1]), mid, t);
        q[4] = lerp_q16(mid, coord_t'(q[5]), t);
        q[3] = lerp_q16(coord_t'(q[2]), coord_t'(q[4]), t);
        return q;
    endfunction

    task automatic predict_split();
        axis_points_t qx;
        axis_points_t qy;
        longint       t;
        ctrl_point_t  pt;
        // t above one saturates to one
        t  = (i_split_t > ONE_T) ? ONE_T : longint'(i_split_t);
        qx = split_axis(i_p0_x, i_p1_x, i_p2_x, i_p3_x, t);
        qy = split_axis(i_p0_y, i_p1_y, i_p2_y, i_p3_y, t);
        for (int k = 0; k < NUM_POINTS; k++) begin
            pt.index = t_idx'(k);
            pt.x     = coord_t'(qx[k]);
            pt.y     = coord_t'(qy[k]);
            pt.last  = (pt.index == LAST_IDX);
            expected_points.push_back(pt);
        end
    endtask

    task automatic check_point();
        ctrl_point_t exp_pt;
        if (expected_points.size() == 0) begin
            $error("unexpected point: point_index %0d, out_x %0d, out_y %0d",
                   o_point_index, o_out_x, o_out_y);
            o_fail_count++;
        end else begin
            exp_pt = expected_points.pop_front();
            if (o_point_index !== exp_pt.index) begin
                $error("point_index mismatch: expected %0d, got %0d",
                       exp_pt.index, o_point_index);
                o_fail_count++;
            end
            if (o_out_x !== exp_pt.x) begin
                $error("out_x mismatch: expected %0d, got %0d", exp_pt.x, o_out_x);
                o_fail_count++;
            end
            if (o_out_y !== exp_pt.y) begin
                $error("out_y mismatch: expected %0d, got %0d", exp_pt.y, o_out_y);
                o_fail_count++;
            end
            if (o_last !== exp_pt.last) begin
                $error("last mismatch: expected %0d, got %0d", exp_pt.last, o_last);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count     = 0;
        o_points_pending = 0;
    end

    // results are checked before a same-cycle item is predicted
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            check_point();
        if (i_rst_n && start && busy === 1'b0)
            predict_split();
        o_points_pending = expected_points.size();
    end

endmodule

`default_nettype wire

>>> verif/cubic_bezier_split_tb.sv
`default_nettype none

module cubic_bezier_split_tb;

    import bzs_pkg::*;

    localparam int COORD_WIDTH = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int ONE_T       = 1 << T_FRAC_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RAND_ITEMS  = 140;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [T_FRAC_BITS:0]          split_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam split_t T_MAX     = '1;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    coord_t        i_p0_x, i_p0_y, i_p1_x, i_p1_y;
    coord_t        i_p2_x, i_p2_y, i_p3_x, i_p3_y;
    split_t        i_split_t;
    logic          o_valid;
    t_idx          o_point_index;
    coord_t        o_out_x;
    coord_t        o_out_y;
    logic          o_last;
    int            fail_count;
    int            points_pending;
    int            stall_cycles;

    cubic_bezier_split #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p0_x(i_p0_x), .i_p0_y(i_p0_y), .i_p1_x(i_p1_x), .i_p1_y(i_p1_y),
        .i_p2_x(i_p2_x), .i_p2_y(i_p2_y), .i_p3_x(i_p3_x), .i_p3_y(i_p3_y),
        .i_split_t(i_split_t), .o_valid(o_valid), .o_point_index(o_point_index),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_last(o_last)
    );

    bezier_split_checker #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) split_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p0_x(i_p0_x), .i_p0_y(i_p0_y), .i_p1_x(i_p1_x), .i_p1_y(i_p1_y),
        .i_p2_x(i_p2_x), .i_p2_y(i_p2_y), .i_p3_x(i_p3_x), .i_p3_y(i_p3_y),
        .i_split_t(i_split_t), .o_valid(o_valid), .o_point_index(o_point_index),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_last(o_last),
        .o_fail_count(fail_count), .o_points_pending(points_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // half full-range values, the rest extremes and small values near zero
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3:    return coord_t'(int'($urandom_range(0, 2047)) - 1024);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic split_t rand_split_t();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return split_t'(ONE_T);
            2:       return split_t'($urandom_range(ONE_T + 1, 2 * ONE_T - 1));
            default: return split_t'($urandom_range(0, ONE_T));
        endcase
    endfunction

    // start is left high after an accept so back-to-back items need no toggle
    task automatic drive_split(coord_t p0x, coord_t p0y, coord_t p1x, coord_t p1y,
                               coord_t p2x, coord_t p2y, coord_t p3x, coord_t p3y,
                               split_t t, int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge i_clk);
        end
        start     <= 1'b1;
        i_p0_x    <= p0x;
        i_p0_y    <= p0y;
        i_p1_x    <= p1x;
        i_p1_y    <= p1y;
        i_p2_x    <= p2x;
        i_p2_y    <= p2y;
        i_p3_x    <= p3x;
        i_p3_y    <= p3y;
        i_split_t <= t;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // hang detection: cycles with no item accepted and no point emitted
    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("cubic_bezier_split regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int idle_pct;
        stall_cycles = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_p0_x       = '0;
        i_p0_y       = '0;
        i_p1_x       = '0;
        i_p1_y       = '0;
        i_p2_x       = '0;
        i_p2_y       = '0;
        i_p3_x       = '0;
        i_p3_y       = '0;
        i_split_t    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of coordinates and of the split parameter
        drive_split('0, '0, '0, '0, '0, '0, '0, '0, '0, 14);
        drive_split(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, split_t'(ONE_T / 2), 14);
        drive_split(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, split_t'(ONE_T / 2), 14);
        drive_split(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                    COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, split_t'(ONE_T / 2), 14);
        drive_split(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                    COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, split_t'(1), 14);
        drive_split(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                    COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, split_t'(ONE_T - 1), 14);
        // split at the start and at the end point
        drive_split(coord_t'(100), coord_t'(-200), COORD_MAX, COORD_MIN,
                    COORD_MIN, COORD_MAX, coord_t'(-300), coord_t'(400), '0, 14);
        drive_split(coord_t'(100), coord_t'(-200), COORD_MAX, COORD_MIN,
                    COORD_MIN, COORD_MAX, coord_t'(-300), coord_t'(400),
                    split_t'(ONE_T), 14);
        // t above one saturates
        drive_split(coord_t'(100), coord_t'(-200), COORD_MAX, COORD_MIN,
                    COORD_MIN, COORD_MAX, coord_t'(-300), coord_t'(400),
                    split_t'(ONE_T + 1), 14);
        drive_split(COORD_MIN, COORD_MAX, coord_t'(5), coord_t'(-5),
                    coord_t'(-7), coord_t'(7), COORD_MAX, COORD_MIN, T_MAX, 14);
        // rounding ties at half, positive and negative
        drive_split(coord_t'(-1), coord_t'(1), coord_t'(0), coord_t'(0),
                    coord_t'(1), coord_t'(-1), coord_t'(0), coord_t'(-2),
                    split_t'(ONE_T / 2), 14);
        drive_split(coord_t'(-3), coord_t'(3), coord_t'(2), coord_t'(-2),
                    coord_t'(-1), coord_t'(1), coord_t'(4), coord_t'(-4),
                    split_t'(ONE_T / 4), 0);
        drive_split(coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1),
                    coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1),
                    split_t'(3 * ONE_T / 4), 0);

        // random: sender idle 14%, then 84%, then back to back
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 84 : 0;
            repeat (RAND_ITEMS)
                drive_split(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_split_t(), idle_pct);
        end
        start <= 1'b0;

        while (points_pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("cubic_bezier_split regression: pass");
        else
            $display("cubic_bezier_split regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
